/* sv/fdl_pkg.sv */
// Shared constants and types for the feedback delay line.
package fdl_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int OFFSET_W   = 13;
    localparam int GAIN_W     = 18;
    localparam int Q_SHIFT    = 16;
    localparam int DEPTH_DEF  = 4096;
    localparam int PTR_MAX_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_OFFSET    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 1'b1;

    localparam logic signed [SAMPLE_W+2:0] SAMPLE_MAX = 19'sd32767;
    localparam logic signed [SAMPLE_W+2:0] SAMPLE_MIN = -19'sd32768;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [PTR_MAX_W-1:0] tmod;
    } red_stat_t;

endpackage

/* sv/fdl_tap_mod.sv */
// Sequential reduction of the signed tap offset modulo the delay depth.
module fdl_tap_mod #(
    parameter int DEPTH = fdl_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [fdl_pkg::OFFSET_W-1:0] offset,
    output fdl_pkg::red_stat_t                  stat
);

    localparam int OW  = fdl_pkg::OFFSET_W;
    localparam int PW  = fdl_pkg::PTR_MAX_W;
    localparam int DPW = $clog2(DEPTH + 1);
    localparam int K   = OW + DPW;
    localparam int RW  = OW + 2;
    localparam int MW  = OW + RW;
    localparam int XW  = OW + DPW;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << K) / 64'(DEPTH));

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_SUB  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_DONE = 5'b10000
    } red_state_t;

    red_state_t     state_reg, state_next;
    logic           neg_reg;
    logic [OW-1:0]  mag_reg;
    logic [OW-1:0]  quo_reg;
    logic [OW-1:0]  rem_reg;
    logic [PW-1:0]  tmod_reg;
    logic [OW-1:0]  mag;
    logic [MW-1:0]  prod;
    logic [XW-1:0]  qd;
    logic [OW-1:0]  rem_fix;
    logic [PW-1:0]  tmod_next;

    assign mag  = offset[OW-1] ? OW'(-offset) : OW'(offset);
    assign prod = MW'(mag_reg) * MW'(RECIP);
    assign qd   = XW'(quo_reg) * XW'(DEPTH);

    // The reciprocal quotient can fall one short, which leaves one more subtraction.
    assign rem_fix = (XW'(rem_reg) >= XW'(DEPTH)) ? OW'(XW'(rem_reg) - XW'(DEPTH))
                                                  : rem_reg;

    always_comb
    begin
        if (neg_reg && (rem_fix != '0))
        begin
            tmod_next = PW'((PW + 1)'(DEPTH) - (PW + 1)'(rem_fix));
        end
        else
        begin
            tmod_next = PW'(rem_fix);
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE: state_next = ST_IDLE;
            ST_MUL:  state_next = ST_SUB;
            ST_SUB:  state_next = ST_FIN;
            ST_FIN:  state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        if (start)
        begin
            state_next = ST_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= offset[OW-1];
            mag_reg <= mag;
        end
        if (state_reg == ST_MUL)
        begin
            quo_reg <= OW'(prod >> K);
        end
        if (state_reg == ST_SUB)
        begin
            rem_reg <= OW'(XW'(mag_reg) - qd);
        end
        if (state_reg == ST_FIN)
        begin
            tmod_reg <= tmod_next;
        end
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);
    assign stat.tmod = tmod_reg;

endmodule

/* sv/feedback_delay_line.sv */
// Top level of the feedback delay line: delay memory, datapath and stream ports.
//
// Input samples arrive on the s_axis channel and echoed samples leave on the
// m_axis channel, one result transaction per input transaction, in order.
// Configuration is written through cfg_we, cfg_index and cfg_data while the
// block is idle: index 0 is the signed tap offset, index 1 the Q16 gain.
// Writing the tap offset starts a reduction modulo DEPTH, during which
// s_axis_tready is low.
// A new input sample is not accepted while the previous one sits in the s1 stage,
// since the single write port of the delay memory takes both the output write and the tap clear.
// A result passes through the s1 and s2 stages and then sits in a
// two-entry output buffer; when the receiver stalls, the buffer fills and
// s_axis_tready drops, so no sample is lost.
// After reset the delay memory is cleared one entry per cycle, all DEPTH entries,
// with s_axis_tready low; the pointers, tap offset and gain reset to zero.
module feedback_delay_line #(
    parameter int DEPTH = fdl_pkg::DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [fdl_pkg::SAMPLE_W-1:0]          s_axis_tdata,   // [15:0] sample_in
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [fdl_pkg::SAMPLE_W-1:0]          m_axis_tdata,   // [15:0] sample_out
    input  logic                                  cfg_we,
    input  logic [fdl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fdl_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int SW = fdl_pkg::SAMPLE_W;
    localparam int OW = fdl_pkg::OFFSET_W;
    localparam int GW = fdl_pkg::GAIN_W;
    localparam int PRW = SW + GW;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    fdl_pkg::red_stat_t red_stat;

    logic signed [OW-1:0]  tap_offset_reg;
    logic signed [GW-1:0]  gain_reg;
    logic                  clr_busy_reg;
    logic [AW-1:0]         clr_addr_reg;
    logic [AW-1:0]         wp_reg;
    logic [AW-1:0]         tap_ptr_reg;
    logic                  s1_reg;
    logic                  s2_reg;
    logic signed [SW-1:0]  x_reg;
    logic                  byp_reg;
    logic                  eq_reg;
    logic [AW-1:0]         tap_a_reg;
    logic [AW-1:0]         wp_a_reg;
    logic signed [PRW-1:0] p_reg;
    logic signed [SW-1:0]  mem [DEPTH];
    logic signed [SW-1:0]  rdata_reg;
    logic                  fwd_hit_reg;
    logic signed [SW-1:0]  fwd_data_reg;
    logic signed [SW-1:0]  fifo_reg [2];
    logic                  fifo_wr_reg;
    logic                  fifo_rd_reg;
    logic [1:0]            fifo_cnt_reg;

    logic                  accept;
    logic                  pop;
    logic                  tap_start;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic signed [SW-1:0]  mem_wdata;
    logic signed [SW-1:0]  rd;
    logic signed [PRW-1:0] p_next;
    logic signed [GW-1:0]  sh;
    logic signed [SW+2:0]  sum;
    logic signed [SW-1:0]  y;
    logic [AW:0]           tap_sum;
    logic [AW-1:0]         tap_ptr_next;
    logic [AW-1:0]         wp_inc;
    logic [AW-1:0]         tap_inc;

    fdl_tap_mod #(
        .DEPTH (DEPTH)
    ) u_tap_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (tap_start),
        .offset (cfg_data[OW-1:0]),
        .stat   (red_stat)
    );

    assign tap_start = cfg_we && (cfg_index == fdl_pkg::REG_TAP_OFFSET);

    assign s_axis_tready = !clr_busy_reg && !red_stat.busy && !s1_reg
                           && ((fifo_cnt_reg == 2'd0) || ((fifo_cnt_reg == 2'd1) && !s2_reg));
    assign accept = s_axis_tvalid && s_axis_tready;
    assign pop    = m_axis_tvalid && m_axis_tready;

    assign wp_inc  = (wp_reg == LAST) ? '0 : wp_reg + AW'(1);
    assign tap_inc = (tap_ptr_reg == LAST) ? '0 : tap_ptr_reg + AW'(1);

    assign tap_sum      = {1'b0, wp_reg} + {1'b0, red_stat.tmod[AW-1:0]};
    assign tap_ptr_next = (tap_sum >= (AW + 1)'(DEPTH)) ? AW'(tap_sum - (AW + 1)'(DEPTH))
                                                        : tap_sum[AW-1:0];

    // The entry read for this sample may be written in the very cycle it is read.
    assign rd     = fwd_hit_reg ? fwd_data_reg : rdata_reg;
    assign p_next = rd * gain_reg;
    assign sh     = GW'(p_reg >>> fdl_pkg::Q_SHIFT);
    assign sum    = (SW + 3)'(x_reg) + (SW + 3)'(sh);

    always_comb
    begin
        if (byp_reg)
        begin
            y = x_reg;
        end
        else if (sum > fdl_pkg::SAMPLE_MAX)
        begin
            y = SW'(fdl_pkg::SAMPLE_MAX);
        end
        else if (sum < fdl_pkg::SAMPLE_MIN)
        begin
            y = SW'(fdl_pkg::SAMPLE_MIN);
        end
        else
        begin
            y = SW'(sum);
        end
    end

    // The reset clear has priority, then the tap clear goes first; when the tap lands on the
    // write pointer the output write is dropped so that the entry ends up cleared.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = tap_a_reg;
        mem_wdata = '0;
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
        end
        else if (s1_reg && !byp_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = tap_a_reg;
        end
        else if (s2_reg && !byp_reg && !eq_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = wp_a_reg;
            mem_wdata = y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg    <= mem[tap_ptr_reg];
        fwd_hit_reg  <= mem_we && (mem_waddr == tap_ptr_reg);
        fwd_data_reg <= mem_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_offset_reg <= '0;
            gain_reg       <= '0;
            clr_busy_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            wp_reg         <= '0;
            tap_ptr_reg    <= '0;
            s1_reg         <= 1'b0;
            s2_reg         <= 1'b0;
            fifo_wr_reg    <= 1'b0;
            fifo_rd_reg    <= 1'b0;
            fifo_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    fdl_pkg::REG_TAP_OFFSET:    tap_offset_reg <= cfg_data[OW-1:0];
                    fdl_pkg::REG_FEEDBACK_GAIN: gain_reg       <= cfg_data[GW-1:0];
                    default:                    gain_reg       <= gain_reg;
                endcase
            end
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (red_stat.done)
            begin
                tap_ptr_reg <= tap_ptr_next;
            end
            else if (accept && (tap_offset_reg != '0))
            begin
                tap_ptr_reg <= tap_inc;
            end
            if (accept && (tap_offset_reg != '0))
            begin
                wp_reg <= wp_inc;
            end
            s1_reg <= accept;
            s2_reg <= s1_reg;
            if (s2_reg)
            begin
                fifo_wr_reg <= !fifo_wr_reg;
            end
            if (pop)
            begin
                fifo_rd_reg <= !fifo_rd_reg;
            end
            fifo_cnt_reg <= fifo_cnt_reg + 2'(s2_reg) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg     <= s_axis_tdata;
            byp_reg   <= (tap_offset_reg == '0);
            eq_reg    <= (tap_ptr_reg == wp_reg);
            tap_a_reg <= tap_ptr_reg;
            wp_a_reg  <= wp_reg;
        end
        if (s1_reg)
        begin
            p_reg <= p_next;
        end
        if (s2_reg)
        begin
            fifo_reg[fifo_wr_reg] <= y;
        end
    end

    assign m_axis_tvalid = (fifo_cnt_reg != 2'd0);
    assign m_axis_tdata  = fifo_reg[fifo_rd_reg];

    a_one_write_per_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_reg && s2_reg))
        else $error("Tap clear and output write of the delay memory overlap.");

    a_buffer_room: assert property (@(posedge clk) disable iff (!rst_n)
        s2_reg |-> (fifo_cnt_reg <= 2'd1))
        else $error("Result arrives while the output buffer is full.");

    a_zero_tap_on_wp: assert property (@(posedge clk) disable iff (!rst_n)
        (!red_stat.busy && (tap_offset_reg == '0)) |-> (tap_ptr_reg == wp_reg))
        else $error("Tap pointer differs from write pointer with a zero offset.");

    a_accept_flow: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (s1_reg && !s_axis_tready))
        else $error("Transaction did not enter the datapath as expected.");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the feedback delay line with a predicting scoreboard.
module tb_top;

    localparam int DEPTH = fdl_pkg::DEPTH_DEF;

    class echo_scoreboard;
        logic signed [fdl_pkg::SAMPLE_W-1:0] delay_store [DEPTH];
        int                                  write_ptr;
        int                                  tap_offset;
        int                                  feedback_gain;
        logic [fdl_pkg::SAMPLE_W-1:0]        expected_samples [$];
        int                                  errors;

        function new();
            foreach (delay_store[i])
                delay_store[i] = '0;
            write_ptr     = 0;
            tap_offset    = 0;
            feedback_gain = 0;
            errors        = 0;
        endfunction

        function void set_reg(logic [fdl_pkg::CFG_IDX_W-1:0] idx,
                              logic [fdl_pkg::CFG_DATA_W-1:0] data);
            if (idx == fdl_pkg::REG_TAP_OFFSET)
                tap_offset = int'($signed(data[fdl_pkg::OFFSET_W-1:0]));
            else if (idx == fdl_pkg::REG_FEEDBACK_GAIN)
                feedback_gain = int'($signed(data[fdl_pkg::GAIN_W-1:0]));
        endfunction

        function void note_sample(logic [fdl_pkg::SAMPLE_W-1:0] raw);
            logic signed [fdl_pkg::SAMPLE_W-1:0] x;
            int                                  t;
            longint                              prod;
            longint                              y;
            x = raw;
            if (tap_offset == 0)
            begin
                expected_samples.push_back(raw);
                return;
            end
            t = (write_ptr + tap_offset) % DEPTH;
            if (t < 0)
                t += DEPTH;
            prod = longint'(delay_store[t]) * longint'(feedback_gain);
            y = longint'(x) + (prod >>> fdl_pkg::Q_SHIFT);
            if (y > 32767)
                y = 32767;
            if (y < -32768)
                y = -32768;
            delay_store[write_ptr] = y[fdl_pkg::SAMPLE_W-1:0];
            delay_store[t] = '0;
            write_ptr = (write_ptr + 1) % DEPTH;
            expected_samples.push_back(y[fdl_pkg::SAMPLE_W-1:0]);
        endfunction

        function void check_sample(logic [fdl_pkg::SAMPLE_W-1:0] actual);
            logic [fdl_pkg::SAMPLE_W-1:0] exp_s;
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected sample_out transaction, expected none, actual %0d",
                         $time, $signed(actual));
                errors++;
                return;
            end
            exp_s = expected_samples.pop_front();
            if (actual !== exp_s)
            begin
                $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                         $time, $signed(exp_s), $signed(actual));
                errors++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [fdl_pkg::SAMPLE_W-1:0]   s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [fdl_pkg::SAMPLE_W-1:0]   m_axis_tdata;
    logic                           cfg_we;
    logic [fdl_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [fdl_pkg::CFG_DATA_W-1:0] cfg_data;

    echo_scoreboard model;
    int             send_idle_pct;
    int             recv_stall_pct;
    bit             hold_request;
    bit             hold_taken = 1'b0;
    int             hold_left = 0;

    feedback_delay_line #(
        .DEPTH(DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(8 * 1000000);
        $display("DONE: errors detected");
        $finish;
    end

    always @(negedge clk)
    begin
        if (hold_request && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left = 500;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready = 1'b0;
        end
        else
            m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            model.check_sample(m_axis_tdata);
    end

    task automatic send_sample(input logic [fdl_pkg::SAMPLE_W-1:0] s);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = s;
        do
            @(posedge clk);
        while (!s_axis_tready);
        model.note_sample(s);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (model.expected_samples.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [fdl_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value[fdl_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        model.set_reg(idx, value[fdl_pkg::CFG_DATA_W-1:0]);
    endtask

    task automatic configure(input int tap, input int gain);
        wait_idle();
        write_reg(fdl_pkg::REG_FEEDBACK_GAIN, gain);
        write_reg(fdl_pkg::REG_TAP_OFFSET, tap);
    endtask

    initial
    begin
        int          tap;
        int          gain;
        logic [15:0] s;
        model          = new();
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'h0000);
        send_sample(16'hffff);
        send_sample(16'h5a5a);

        configure(-1, 32'h10000);
        send_sample(16'h7fff);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h8000);

        configure(-1, -65536);
        send_sample(16'h7fff);
        send_sample(16'h7fff);
        send_sample(16'h8000);

        configure(-2, 32'h1ffff);
        send_sample(16'h4000);
        send_sample(16'h4000);
        send_sample(16'h4000);

        configure(-1, -131072);
        send_sample(16'h1234);
        send_sample(16'h1234);

        configure(-1, 1);
        send_sample(16'hffff);
        send_sample(16'h0000);

        configure(-4096, 32'h10000);
        send_sample(16'h7000);
        send_sample(16'h1000);

        configure(4095, 32'h10000);
        send_sample(16'h2222);
        configure(-4095, 32'h10000);
        send_sample(16'h3333);

        for (int seg = 0; seg < 12; seg++)
        begin
            case ($urandom_range(7))
                0:       tap = 4095;
                1:       tap = -4096;
                2:       tap = -4095;
                3:       tap = int'($urandom_range(8191)) - 4096;
                4:       tap = 0;
                default: tap = -int'($urandom_range(64, 1));
            endcase
            case ($urandom_range(5))
                0:       gain = 65536;
                1:       gain = -65536;
                2:       gain = int'($urandom());
                3:       gain = 0;
                default: gain = int'($urandom_range(131072)) - 65536;
            endcase
            configure(tap, gain);
            case (seg % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 88;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 88;
                end
                default:
                begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 15;
                end
            endcase
            if (seg == 4)
                hold_request = 1'b1;
            for (int n = 0; n < 127; n++)
            begin
                case ($urandom_range(9))
                    0:       s = 16'h7fff;
                    1:       s = 16'h8000;
                    default: s = 16'($urandom());
                endcase
                send_sample(s);
            end
        end

        wait_idle();
        if (model.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
